>>> design/wctm_pkg.sv
// types and constants shared by the wall column texture mapper
// no dependencies; imported by every module of the block

package wctm_pkg;

  // item kinds carried in tuser
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // hit side codes
  localparam logic SIDE_X = 1'b0;
  localparam logic SIDE_Y = 1'b1;

  // texture choice
  localparam logic [1:0] TEX_Y_FAR  = 2'd0;
  localparam logic [1:0] TEX_Y_NEAR = 2'd1;
  localparam logic [1:0] TEX_X_NEAR = 2'd2;
  localparam logic [1:0] TEX_X_FAR  = 2'd3;

  localparam int SCREEN_ROWS = 480;
  localparam int HALF_ROWS   = SCREEN_ROWS / 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int IN_BITS  = 123;
  localparam int IN_BYTES = 16;
  localparam int OUT_BITS = 33;
  localparam int OUT_BYTES = 5;

  // input payload, last field (column_x) in the lowest bits
  typedef struct packed {
    logic [8:0]         draw_end_y;
    logic [8:0]         draw_start_y;
    logic [15:0]        wall_height;
    logic signed [17:0] dir_y;
    logic signed [17:0] dir_x;
    logic [25:0]        wall_distance;
    logic [7:0]         map_cell_y;
    logic [7:0]         map_cell_x;
    logic               hit_side;
    logic [9:0]         column_x;
  } in_item_t;

  // result payload, last field (pixel_x) in the lowest bits
  typedef struct packed {
    logic [5:0] texel_y;
    logic [5:0] texel_x;
    logic [1:0] texture_index;
    logic [8:0] pixel_y;
    logic [9:0] pixel_x;
  } out_item_t;

  // classified operation passed from front to back
  typedef struct packed {
    logic        kind;
    logic [9:0]  column_x;
    logic [1:0]  texture;
    logic        mirror;
    logic [15:0] hit_frac;
    logic [15:0] wall_height;
    logic [8:0]  draw_start_y;
    logic [8:0]  draw_end_y;
  } op_t;

endpackage

>>> design/wctm_front.sv
// front end: input register, hit point multiply and texture classification
// depends on wctm_pkg

module wctm_front
  import wctm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  in_item_t    in_item,
  input  logic [23:0] player_pos_x,
  input  logic [23:0] player_pos_y,
  output logic        op_valid,
  input  logic        op_ready,
  output op_t         op
);

  logic               held_valid;
  logic               held_kind;
  in_item_t           held;
  logic signed [44:0] hit_prod;
  logic signed [17:0] dir_sel;
  logic [15:0]        pos_lo;

  assign in_ready = !held_valid || op_ready;
  assign op_valid = held_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      held_kind <= in_kind;
      held      <= in_item;
    end
  end

  // along the wall: y for an x-side hit, x for a y-side hit
  assign dir_sel  = (held.hit_side == SIDE_Y) ? held.dir_x : held.dir_y;
  assign pos_lo   = (held.hit_side == SIDE_Y) ? player_pos_x[15:0] : player_pos_y[15:0];
  assign hit_prod = $signed({19'd0, held.wall_distance}) * 45'(dir_sel);

  always_comb begin
    op.kind         = held_kind;
    op.column_x     = held.column_x;
    op.wall_height  = held.wall_height;
    op.draw_start_y = held.draw_start_y;
    op.draw_end_y   = held.draw_end_y;
    // bits 31:16 of the product are the low half of the floor-shifted offset
    op.hit_frac     = pos_lo + hit_prod[31:16];
    if (held.hit_side == SIDE_Y) begin
      op.texture = (player_pos_y <= {held.map_cell_y, 16'd0}) ? TEX_Y_NEAR : TEX_Y_FAR;
      op.mirror  = held.dir_y[17];
    end else begin
      op.texture = (player_pos_x <= {held.map_cell_x, 16'd0}) ? TEX_X_NEAR : TEX_X_FAR;
      op.mirror  = !held.dir_x[17] && (held.dir_x != 18'sd0);
    end
  end

endmodule

>>> design/wctm_queue.sv
// short fifo of classified operations between front and back
// depends on wctm_pkg

module wctm_queue
  import wctm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  op_t  wr_op,
  input  logic rd_ready,
  output logic rd_valid,
  output op_t  rd_op
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              push;
  logic              pop;

  assign wr_ready = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_ready && rd_valid;
  assign rd_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
    if (push) begin
      slots[wr_ptr] <= wr_op;
    end
  end

endmodule

>>> design/wctm_back.sv
// back end: column state, step divider, start position multiply and pixel output
// depends on wctm_pkg

module wctm_back
  import wctm_pkg::*;
#(
  parameter int TEX_SIZE = 64
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  output logic      op_ready,
  input  op_t       op,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  output logic      out_last
);

  localparam int DW = $clog2(TEX_SIZE) + 17;
  localparam int CW = $clog2(DW);
  localparam logic [DW-1:0] DIVIDEND = DW'(TEX_SIZE) << 16;
  localparam logic [5:0]    TMASK    = 6'((TEX_SIZE - 1) % 64);

  typedef enum logic [1:0] {ST_RUN, ST_DIV, ST_MUL} state_t;

  state_t      state;
  logic        active;
  logic [9:0]  column;
  logic [9:0]  cur_row;
  logic [9:0]  end_row;
  logic [31:0] tex_pos;
  logic [31:0] step;
  logic [1:0]  texture;
  logic [5:0]  tex_x;
  logic [15:0] height;
  logic [8:0]  start_row;
  logic [15:0] rem;
  logic [DW-1:0] quot;
  logic [CW-1:0] count;

  logic        out_free;
  logic        emit;
  logic [16:0] rem_shift;
  logic        rem_ge;
  logic [15:0] rem_next;
  logic [DW-1:0] quot_next;
  logic [31:0] frac_scaled;
  logic [31:0] tx_full;
  logic [31:0] offset;
  logic [9:0]  row_inc;

  assign out_free = !out_valid || out_ready;
  assign op_ready = op_valid && (state == ST_RUN) && ((op.kind == KIND_LOAD) || out_free);
  // a tick taken on an active column produces a beat
  assign emit = op_ready && (op.kind == KIND_TICK) && active && (cur_row < end_row);

  // restoring divider, one quotient bit a cycle
  assign rem_shift = {rem, quot[DW-1]};
  assign rem_ge    = rem_shift >= {1'b0, height};
  assign rem_next  = rem_ge ? 16'(rem_shift - {1'b0, height}) : rem_shift[15:0];
  assign quot_next = {quot[DW-2:0], rem_ge};

  assign frac_scaled = 32'(op.hit_frac) * 32'(TEX_SIZE);
  assign tx_full     = op.mirror ? (32'(TEX_SIZE) - (frac_scaled >> 16) - 32'd1)
                                 : (frac_scaled >> 16);
  assign offset  = 32'(start_row) - 32'(HALF_ROWS) + 32'(height >> 1);
  assign row_inc = cur_row + 10'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_RUN: begin
          if (op_ready) begin
            if (op.kind == KIND_LOAD) begin
              texture   <= op.texture;
              tex_x     <= tx_full[5:0];
              column    <= op.column_x;
              cur_row   <= 10'(op.draw_start_y);
              end_row   <= 10'(op.draw_end_y);
              start_row <= op.draw_start_y;
              height    <= op.wall_height;
              active    <= op.draw_start_y < op.draw_end_y;
              if (op.wall_height == 16'd0) begin
                // zero height saturates the step
                step  <= '1;
                state <= ST_MUL;
              end else begin
                rem   <= '0;
                quot  <= DIVIDEND;
                count <= CW'(DW - 1);
                state <= ST_DIV;
              end
            end else if (active && (cur_row < end_row)) begin
              out_item.pixel_x       <= column;
              out_item.pixel_y       <= cur_row[8:0];
              out_item.texture_index <= texture;
              out_item.texel_x       <= tex_x;
              out_item.texel_y       <= tex_pos[21:16] & TMASK;
              out_last               <= row_inc >= end_row;
              tex_pos                <= tex_pos + step;
              cur_row                <= row_inc;
              if (row_inc >= end_row) active <= 1'b0;
            end else begin
              active <= 1'b0;
            end
          end
        end
        ST_DIV: begin
          rem   <= rem_next;
          quot  <= quot_next;
          count <= count - 1'b1;
          if (count == '0) begin
            step  <= 32'(quot_next);
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          tex_pos <= offset * step;
          state   <= ST_RUN;
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

>>> design/wall_column_texture_mapper.sv
// top level of the wall column texture mapper: config registers and the
// front, queue and back instances; depends on wctm_pkg and the wctm_* modules
//
// usage
//   s_axis carries items: tuser is the kind (0 loads a column, 1 is a pixel
//   tick), tdata the load fields. m_axis returns one pixel beat per tick
//   while a column is active; tlast marks the bottom pixel of the column.
//   ticks with no active column are swallowed without a beat. the user must
//   write player position on the cfg port while idle; it is not enforced.
// throughput
//   a tick's beat is registered when the back end takes the tick; ticks run
//   at one per cycle as long as m_axis keeps up. a load holds the back end
//   for a setup step, the quotient bits of the step divider and the start
//   position multiply; a zero wall height skips the divider. the four-entry
//   queue lets the input keep taking beats meanwhile.
// reset and stall
//   rst clears the config registers, the queue and the column state.
//   when m_axis stalls the result is held and the queue fills, then
//   s_axis_tready drops.

module wall_column_texture_mapper
  import wctm_pkg::*;
#(
  parameter int TEX_SIZE = 64
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // column_x, hit_side, map_cell_x, map_cell_y, wall_distance, dir_x, dir_y,
  // wall_height, draw_start_y, draw_end_y, zero fill
  input  logic [IN_BYTES*8-1:0]  s_axis_tdata,
  // kind
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // pixel_x, pixel_y, texture_index, texel_x, texel_y, zero fill
  output logic [OUT_BYTES*8-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  logic [23:0]            cfg_data
);

  localparam logic REG_POS_X = 1'b0;
  localparam logic REG_POS_Y = 1'b1;

  logic [23:0] player_pos_x;
  logic [23:0] player_pos_y;
  logic        front_valid;
  logic        queue_wr_ready;
  op_t         front_op;
  logic        back_ready;
  logic        queue_valid;
  op_t         queue_op;
  out_item_t   result;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_pos_x <= '0;
      player_pos_y <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_POS_X: player_pos_x <= cfg_data;
        REG_POS_Y: player_pos_y <= cfg_data;
        default: ;
      endcase
    end
  end

  wctm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_kind      (s_axis_tuser),
    .in_item      (in_item_t'(s_axis_tdata[IN_BITS-1:0])),
    .player_pos_x (player_pos_x),
    .player_pos_y (player_pos_y),
    .op_valid     (front_valid),
    .op_ready     (queue_wr_ready),
    .op           (front_op)
  );

  wctm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (queue_wr_ready),
    .wr_op    (front_op),
    .rd_ready (back_ready),
    .rd_valid (queue_valid),
    .rd_op    (queue_op)
  );

  wctm_back #(
    .TEX_SIZE (TEX_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (queue_valid),
    .op_ready  (back_ready),
    .op        (queue_op),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (result),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_BYTES*8-OUT_BITS)'(0), result};

endmodule
